/* rtl/core/pts_pkg.sv */
package pts_pkg;

	typedef enum logic [1:0] {
		CLS_LETTER = 2'd0,
		CLS_DIGIT  = 2'd1,
		CLS_SPACE  = 2'd2,
		CLS_OTHER  = 2'd3
	} cls_t;

	typedef enum logic [2:0] {
		PH_START   = 3'd0,
		PH_RUN     = 3'd1,
		PH_WS_ONE  = 3'd2,
		PH_WS_MANY = 3'd3,
		PH_APOS    = 3'd4,
		PH_HOLD    = 3'd5
	} phase_t;

	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_S    = 8'h73;
	localparam logic [7:0] CH_T    = 8'h74;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_D    = 8'h64;
	localparam logic [7:0] CH_R    = 8'h72;
	localparam logic [7:0] CH_V    = 8'h76;
	localparam logic [7:0] CH_L    = 8'h6C;
	localparam logic [7:0] CH_E    = 8'h65;

	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       piece_start;
		logic       last_of_text;
	} result_t;

	// up to two results per transfer; when both are valid, first is the held byte
	typedef struct packed {
		logic    first_valid;
		logic    second_valid;
		result_t first;
		result_t second;
	} push_t;

	function automatic cls_t class_of(input logic [7:0] b);
		cls_t c;
		if (b[7])
			c = CLS_OTHER;
		else if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D))
			c = CLS_SPACE;
		else if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A))
			c = CLS_LETTER;
		else if (b >= 8'h30 && b <= 8'h39)
			c = CLS_DIGIT;
		else
			c = CLS_OTHER;
		return c;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A)
			r = b | 8'h20;
		return r;
	endfunction

	// phase after a byte that opens a piece
	function automatic phase_t begin_phase(input logic [7:0] b, input logic last);
		phase_t p;
		if (class_of(b) == CLS_SPACE)
			p = PH_WS_ONE;
		else if (b == CH_APOS && !last)
			p = PH_APOS;
		else
			p = PH_RUN;
		return p;
	endfunction

endpackage

/* rtl/core/pts_in_if.sv */
interface pts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source(output valid, output text_byte, output end_of_text, input ready);
	modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

/* rtl/core/pts_out_if.sv */
interface pts_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       piece_start;
	logic       last_of_text;

	modport source(output valid, output out_byte, output piece_start, output last_of_text,
		input ready);
	modport sink(input valid, input out_byte, input piece_start, input last_of_text,
		output ready);
endinterface

/* rtl/core/byte_pretoken_splitter_unit.sv */
// Byte pretoken splitter.
// text_in (sink): one text byte per transfer, end_of_text set on the last byte.
// piece_out (source): every byte comes back in order, piece_start marking the
// first byte of each pretoken piece, last_of_text on the final byte.
// Throughput: one byte per cycle sustained while the output queue has room.
// An input transfer reaches piece_out through the input register, then the output queue.
// A possible three-byte contraction (apostrophe, then r/v/l) holds its second
// byte back until the next byte has arrived; that byte then leaves together
// with the held one, both written into the queue in one cycle.
// The output queue holds four results; the parser moves a byte on only while
// at least two slots are free, so a stalled receiver backs up through the
// input register into text_in and nothing is dropped.
// Reset (arst_n low) empties the queue and returns the parser to the start of
// a text; the same parser state is restored after each end_of_text byte.
module byte_pretoken_splitter_unit (
	input  logic       clk,
	input  logic       arst_n,
	pts_in_if.sink     text_in,
	pts_out_if.source  piece_out
);

	pts_pkg::push_t push;
	logic           room;

	pts_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_in),
		.room    (room),
		.push    (push)
	);

	pts_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.piece_out (piece_out)
	);

endmodule

/* rtl/core/pts_parser.sv */
module pts_parser (
	input  logic              clk,
	input  logic              arst_n,
	pts_in_if.sink            text_in,
	input  logic              room,
	output pts_pkg::push_t    push
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	pts_pkg::phase_t      phase_q;
	pts_pkg::cls_t        run_class_q;
	logic [7:0]           held_q;

	logic                 advance;
	pts_pkg::phase_t      phase_d;
	pts_pkg::cls_t        run_class_d;
	pts_pkg::cls_t        cls;
	logic [7:0]           lc;
	logic [7:0]           hl;
	logic                 start_f;
	logic                 emit_held;
	logic                 held_start;
	logic                 hold_now;
	logic                 hit;

	assign advance       = valid_s1 && room;
	assign text_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			byte_s1 <= text_in.text_byte;
			last_s1 <= text_in.end_of_text;
		end
		if (advance && hold_now)
			held_q <= byte_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= pts_pkg::PH_START;
			run_class_q <= pts_pkg::CLS_LETTER;
		end else if (advance) begin
			phase_q     <= phase_d;
			run_class_q <= run_class_d;
		end
	end

	always_comb begin
		cls         = pts_pkg::class_of(byte_s1);
		lc          = pts_pkg::to_lower(byte_s1);
		hl          = pts_pkg::to_lower(held_q);
		hit         = ((hl == pts_pkg::CH_R || hl == pts_pkg::CH_V) && lc == pts_pkg::CH_E) ||
		              (hl == pts_pkg::CH_L && lc == pts_pkg::CH_L);
		start_f     = 1'b1;
		emit_held   = 1'b0;
		held_start  = 1'b1;
		hold_now    = 1'b0;
		phase_d     = phase_q;
		run_class_d = run_class_q;
		case (phase_q)
			pts_pkg::PH_RUN: begin
				if (cls == run_class_q) begin
					start_f = 1'b0;
				end else begin
					phase_d     = pts_pkg::begin_phase(byte_s1, last_s1);
					run_class_d = cls;
				end
			end
			pts_pkg::PH_WS_ONE: begin
				// lone space folds into the next run
				start_f = 1'b0;
				if (cls == pts_pkg::CLS_SPACE) begin
					phase_d = pts_pkg::PH_WS_MANY;
				end else begin
					phase_d     = pts_pkg::PH_RUN;
					run_class_d = cls;
				end
			end
			pts_pkg::PH_WS_MANY: begin
				if (cls == pts_pkg::CLS_SPACE) begin
					start_f = 1'b0;
				end else begin
					phase_d     = pts_pkg::begin_phase(byte_s1, last_s1);
					run_class_d = cls;
				end
			end
			pts_pkg::PH_APOS: begin
				if (lc == pts_pkg::CH_S || lc == pts_pkg::CH_T || lc == pts_pkg::CH_M ||
				    lc == pts_pkg::CH_D) begin
					start_f = 1'b0;
					phase_d = pts_pkg::PH_START;
				end else if ((lc == pts_pkg::CH_R || lc == pts_pkg::CH_V ||
				              lc == pts_pkg::CH_L) && !last_s1) begin
					hold_now = 1'b1;
					phase_d  = pts_pkg::PH_HOLD;
				end else if (cls == pts_pkg::CLS_OTHER) begin
					start_f     = 1'b0;
					phase_d     = pts_pkg::PH_RUN;
					run_class_d = pts_pkg::CLS_OTHER;
				end else begin
					phase_d     = pts_pkg::begin_phase(byte_s1, last_s1);
					run_class_d = cls;
				end
			end
			pts_pkg::PH_HOLD: begin
				emit_held = 1'b1;
				if (hit) begin
					held_start = 1'b0;
					start_f    = 1'b0;
					phase_d    = pts_pkg::PH_START;
				end else if (cls == pts_pkg::CLS_LETTER) begin
					start_f     = 1'b0;
					phase_d     = pts_pkg::PH_RUN;
					run_class_d = pts_pkg::CLS_LETTER;
				end else begin
					phase_d     = pts_pkg::begin_phase(byte_s1, last_s1);
					run_class_d = cls;
				end
			end
			default: begin
				phase_d     = pts_pkg::begin_phase(byte_s1, last_s1);
				run_class_d = cls;
			end
		endcase
		if (last_s1) begin
			phase_d     = pts_pkg::PH_START;
			run_class_d = pts_pkg::CLS_LETTER;
		end
	end

	always_comb begin
		push.first_valid         = advance && !hold_now;
		push.second_valid        = advance && emit_held;
		push.second.out_byte     = byte_s1;
		push.second.piece_start  = start_f;
		push.second.last_of_text = last_s1;
		if (emit_held) begin
			push.first.out_byte     = held_q;
			push.first.piece_start  = held_start;
			push.first.last_of_text = 1'b0;
		end else begin
			push.first = push.second;
		end
	end

`ifndef ASSERT_OFF
	a_two_only_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		push.second_valid |-> phase_q == pts_pkg::PH_HOLD)
		else $error("two results outside the held-byte phase");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> phase_q == pts_pkg::PH_START)
		else $error("phase not cleared after end of text");
`endif

endmodule

/* rtl/core/pts_outq.sv */
module pts_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  pts_pkg::push_t    push,
	output logic              room,
	pts_out_if.source         piece_out
);

	pts_pkg::result_t                 mem_q [pts_pkg::OUTQ_DEPTH];
	logic [pts_pkg::OUTQ_AW-1:0]      wr_ptr_q;
	logic [pts_pkg::OUTQ_AW-1:0]      rd_ptr_q;
	logic [pts_pkg::OUTQ_CW-1:0]      count_q;
	logic [pts_pkg::OUTQ_CW-1:0]      push_cnt;
	logic                             pop;
	logic [pts_pkg::OUTQ_AW-1:0]      wr_next;
	pts_pkg::result_t                 head;

	assign push_cnt = pts_pkg::OUTQ_CW'(push.first_valid) + pts_pkg::OUTQ_CW'(push.second_valid);
	assign pop      = piece_out.valid && piece_out.ready;
	assign wr_next  = wr_ptr_q + pts_pkg::OUTQ_AW'(1);
	// a transfer into the queue may carry two results
	assign room     = count_q <= pts_pkg::OUTQ_CW'(pts_pkg::OUTQ_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_cnt[pts_pkg::OUTQ_AW-1:0];
			if (pop)
				rd_ptr_q <= rd_ptr_q + pts_pkg::OUTQ_AW'(1);
			count_q <= count_q + push_cnt - pts_pkg::OUTQ_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.first_valid)
			mem_q[wr_ptr_q] <= push.first;
		if (push.second_valid)
			mem_q[wr_next] <= push.second;
	end

	assign head                   = mem_q[rd_ptr_q];
	assign piece_out.valid        = count_q != '0;
	assign piece_out.out_byte     = head.out_byte;
	assign piece_out.piece_start  = head.piece_start;
	assign piece_out.last_of_text = head.last_of_text;

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pts_pkg::OUTQ_CW'(pts_pkg::OUTQ_DEPTH))
		else $error("output queue overflow");
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.second_valid |-> push.first_valid)
		else $error("second result pushed without first");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.first_valid |-> room)
		else $error("push into full queue");
	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 && push.first_valid |=> piece_out.valid)
		else $error("pushed result not shown");
`endif

endmodule
